// ----- hw/rtl/lsia_pkg.sv -----
`default_nettype none

package lsia_pkg;

  // Width of an interval identifier and of a register index within its class.
  localparam int ID_W  = 16;
  localparam int IDX_W = 3;

  // Result kinds reported for each interval.
  typedef enum logic [1:0] {
    OUT_DATA     = 2'd0,
    OUT_ADDR     = 2'd1,
    OUT_SPILL    = 2'd2,
    OUT_PRECOLOR = 2'd3
  } lsia_outcome_t;

  // Per-item control sent from the top level to one register class bank.
  typedef struct packed {
    logic step;    // an item is being processed this cycle
    logic clear;   // free every slot first (new procedure)
    logic expire;  // free slots whose end lies before the start
    logic alloc;   // this class is the one the item wants
  } lsia_bank_ctl_t;

  // Per-item answer from one register class bank.
  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] index;
    logic             victim_valid;
    logic [ID_W-1:0]  victim_id;
  } lsia_bank_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lsia_slot_bank.sv -----
`default_nettype none

module lsia_slot_bank #(
  parameter int N     = 5,
  parameter int POS_W = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire lsia_pkg::lsia_bank_ctl_t ctl,
  input  wire logic [lsia_pkg::ID_W-1:0] cur_id,
  input  wire logic [POS_W-1:0]         cur_start,
  input  wire logic [POS_W-1:0]         cur_end,
  output lsia_pkg::lsia_bank_res_t      res
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]                busy;
  logic [N-1:0]                busy_exp;
  logic [N-1:0]                busy_next;
  logic [POS_W-1:0]            slot_end   [N];
  logic [lsia_pkg::ID_W-1:0]   slot_owner [N];

  logic                        free_found;
  logic [IW-1:0]               free_idx;
  logic [IW-1:0]               cand_idx;
  logic [POS_W-1:0]            cand_end;
  logic                        take_victim;
  logic                        granted;
  logic [IW-1:0]               wr_idx;

  // Clear on a new procedure, then drop slots that ended before the start.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      busy_exp[k] = busy[k] && !ctl.clear && !(ctl.expire && (slot_end[k] < cur_start));
    end
  end

  // Lowest free slot: scan downward so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (!busy_exp[k]) begin
        free_found = 1'b1;
        free_idx   = IW'(k);
      end
    end
  end

  // Latest end among the slots; a strict compare keeps the lowest index on ties.
  // Only used when no slot is free, so every slot is busy then.
  always_comb begin
    cand_idx = '0;
    cand_end = slot_end[0];
    for (int k = 1; k < N; k++) begin
      if (slot_end[k] > cand_end) begin
        cand_idx = IW'(k);
        cand_end = slot_end[k];
      end
    end
  end

  assign take_victim = ctl.alloc && !free_found && (cand_end > cur_end);
  assign granted     = ctl.alloc && (free_found || take_victim);
  assign wr_idx      = free_found ? free_idx : cand_idx;

  always_comb begin
    busy_next = busy_exp;
    if (granted) begin
      busy_next[wr_idx] = 1'b1;
    end
  end

  // Answer for the current item.
  always_comb begin
    res.granted      = granted;
    res.index        = granted ? lsia_pkg::IDX_W'(wr_idx) : '0;
    res.victim_valid = take_victim;
    res.victim_id    = take_victim ? slot_owner[cand_idx] : '0;
  end

  // Busy bits are control state and reset to free.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (ctl.step) begin
      busy <= busy_next;
    end
  end

  // Owner and end are only read while busy, so they need no reset.
  always_ff @(posedge clk) begin
    if (ctl.step && granted) begin
      slot_end[wr_idx]   <= cur_end;
      slot_owner[wr_idx] <= cur_id;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/linear_scan_interval_allocator_core.sv -----
`default_nettype none

// Linear scan register allocator.
// Input items arrive on the s_axis channel in order of rising start position,
// one live interval each. Every item yields exactly one result item on the
// m_axis channel: the register granted within its class (data or address),
// a spill, or a precolored pass-through, plus the id of any earlier interval
// that lost its register.
// An accepted item is held in the input register; its result is then
// registered in the result register and presented with m_axis_tvalid.
// Throughput: one item per cycle while the result is taken. The slot expiry,
// the lowest-free pick and the latest-end pick over all slots of a class are
// combinational between the input and result registers; the slot state is
// written with the result register, so the next item sees it at once.
// Reset (rst, synchronous) frees every slot and empties both registers.
// When the receiver holds m_axis_tready low, the result holds; the input
// register still takes one more item, then s_axis_tready falls until the
// result is taken.
module linear_scan_interval_allocator_core #(
  parameter int DATA_REGS = 5,
  parameter int ADDR_REGS = 2,
  parameter int POS_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] interval_id, [31:16] start_pos, [47:32] end_pos, [48] begins_run,
  // [55:49] zero
  input  wire logic [55:0] s_axis_tdata,
  // [0] needs_addr_reg, [1] precolored
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] result_id, [18:16] reg_index, [19] victim_valid, [35:20] victim_id,
  // [39:36] zero
  output logic [39:0]      m_axis_tdata,
  // [1:0] outcome
  output logic [1:0]       m_axis_tuser
);

  // Positions are compared in their low bits only, never more than 16.
  localparam int POS_W = (POS_BITS < 16) ? POS_BITS : 16;

  // Input register.
  logic                        in_valid;
  logic [lsia_pkg::ID_W-1:0]   in_id;
  logic [POS_W-1:0]            in_start;
  logic [POS_W-1:0]            in_end;
  logic                        in_run;
  logic                        in_want_addr;
  logic                        in_pre;

  // Result register.
  logic                        out_valid;
  logic [lsia_pkg::ID_W-1:0]   out_id;
  lsia_pkg::lsia_outcome_t     out_outcome;
  logic [lsia_pkg::IDX_W-1:0]  out_index;
  logic                        out_vvalid;
  logic [lsia_pkg::ID_W-1:0]   out_vid;

  logic                        advance;
  logic                        fire;
  logic                        s_fire;
  lsia_pkg::lsia_bank_ctl_t    data_ctl;
  lsia_pkg::lsia_bank_ctl_t    addr_ctl;
  lsia_pkg::lsia_bank_res_t    data_res;
  lsia_pkg::lsia_bank_res_t    addr_res;
  lsia_pkg::lsia_bank_res_t    sel_res;
  lsia_pkg::lsia_outcome_t     outcome_next;

  // Handshake: the result register frees when empty or taken.
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_id        <= s_axis_tdata[15:0];
      in_start     <= s_axis_tdata[16 +: POS_W];
      in_end       <= s_axis_tdata[32 +: POS_W];
      in_run       <= s_axis_tdata[48];
      in_want_addr <= s_axis_tuser[0];
      in_pre       <= s_axis_tuser[1];
    end
  end

  // Both classes expire on every non-precolored item; only one allocates.
  always_comb begin
    data_ctl.step   = fire;
    data_ctl.clear  = in_run;
    data_ctl.expire = !in_pre;
    data_ctl.alloc  = !in_pre && !in_want_addr;
    addr_ctl.step   = fire;
    addr_ctl.clear  = in_run;
    addr_ctl.expire = !in_pre;
    addr_ctl.alloc  = !in_pre && in_want_addr;
  end

  lsia_slot_bank #(
    .N     (DATA_REGS),
    .POS_W (POS_W)
  ) u_data_bank (
    .clk       (clk),
    .rst       (rst),
    .ctl       (data_ctl),
    .cur_id    (in_id),
    .cur_start (in_start),
    .cur_end   (in_end),
    .res       (data_res)
  );

  lsia_slot_bank #(
    .N     (ADDR_REGS),
    .POS_W (POS_W)
  ) u_addr_bank (
    .clk       (clk),
    .rst       (rst),
    .ctl       (addr_ctl),
    .cur_id    (in_id),
    .cur_start (in_start),
    .cur_end   (in_end),
    .res       (addr_res)
  );

  // Pick the answer of the wanted class and form the outcome.
  assign sel_res = in_want_addr ? addr_res : data_res;

  always_comb begin
    if (in_pre) begin
      outcome_next = lsia_pkg::OUT_PRECOLOR;
    end else if (!sel_res.granted) begin
      outcome_next = lsia_pkg::OUT_SPILL;
    end else if (in_want_addr) begin
      outcome_next = lsia_pkg::OUT_ADDR;
    end else begin
      outcome_next = lsia_pkg::OUT_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_id      <= in_id;
      out_outcome <= outcome_next;
      out_index   <= sel_res.index;
      out_vvalid  <= sel_res.victim_valid;
      out_vid     <= sel_res.victim_id;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_vid, out_vvalid, out_index, out_id};
  assign m_axis_tuser  = out_outcome;

  // A victim is only reported when the current item took a register.
  a_victim_granted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_vvalid) |->
      (out_outcome == lsia_pkg::OUT_DATA || out_outcome == lsia_pkg::OUT_ADDR))
    else $error("victim reported without a granted register");

  // Unused result fields read as zero.
  a_vid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_vvalid) |-> (out_vid == '0))
    else $error("victim id not zero without a victim");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_outcome == lsia_pkg::OUT_SPILL ||
                   out_outcome == lsia_pkg::OUT_PRECOLOR)) |-> (out_index == '0))
    else $error("register index not zero for spill or precolored");

  // An item held in the input register is never lost while the result stalls.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_id)))
    else $error("pending item dropped during a stall");

endmodule

`default_nettype wire

// ----- tb/sv/linear_scan_interval_allocator_core_tb.sv -----
`timescale 1ns / 1ps

module linear_scan_interval_allocator_core_tb;

  localparam int DATA_SLOTS = 5;
  localparam int ADDR_SLOTS = 2;
  localparam int CLS_DATA   = 0;
  localparam int CLS_ADDR   = 1;
  localparam int RANDOM_ITEMS = 1200;

  // One live interval as offered on the input side, plus its pacing.
  typedef struct {
    logic [lsia_pkg::ID_W-1:0] id;
    logic [15:0]               start_pos;
    logic [15:0]               end_pos;
    logic                      addr;
    logic                      pre;
    logic                      run;
    int                        gap_after;
    bit                        drain;
  } interval_t;

  // Expected allocation decision for one interval.
  typedef struct {
    logic [lsia_pkg::ID_W-1:0]  id;
    lsia_pkg::lsia_outcome_t    outcome;
    logic [lsia_pkg::IDX_W-1:0] reg_idx;
    logic                       victim_valid;
    logic [lsia_pkg::ID_W-1:0]  victim_id;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  linear_scan_interval_allocator_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  interval_t pending_q[$];
  grant_t    grant_q[$];
  interval_t cur_iv;

  int gap_left       = 0;
  int stall_left     = 0;
  int next_stall     = 0;
  int long_hold_left = 0;
  bit long_hold_done = 0;
  int sent_cnt       = 0;
  int recv_cnt       = 0;
  int err_cnt        = 0;
  int fill_cnt       = 0;
  int n_spill        = 0;
  int n_victim       = 0;
  int n_precolor     = 0;

  // Allocator state: one row of slots per register class.
  bit                          slot_busy  [2][8];
  bit [15:0]                   slot_end   [2][8];
  bit [lsia_pkg::ID_W-1:0]     slot_owner [2][8];

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    err_cnt++;
    if (err_cnt <= 20) begin
      $display("MISMATCH at %0t ns: %s, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Builds one interval; pacing follows the position in the input stream.
  function automatic interval_t interval_item(input logic [lsia_pkg::ID_W-1:0] id,
                                              input logic [15:0] start_pos,
                                              input logic [15:0] end_pos,
                                              input logic addr, input logic pre,
                                              input logic run);
    interval_t iv;
    iv.id        = id;
    iv.start_pos = start_pos;
    iv.end_pos   = end_pos;
    iv.addr      = addr;
    iv.pre       = pre;
    iv.run       = run;
    iv.drain     = (fill_cnt % 250 == 249);
    // Back-to-back stretches, including the window of the long output hold.
    if ((fill_cnt >= 380 && fill_cnt < 480) || ((fill_cnt / 100) % 4 == 1)) begin
      iv.gap_after = 0;
    end else begin
      iv.gap_after = $urandom_range(0, 8);
    end
    fill_cnt++;
    return iv;
  endfunction

  // Decides the register for one interval and updates the slot state.
  function automatic grant_t assign_register(input interval_t iv);
    grant_t g;
    int     cls;
    int     k;
    int     cand;
    int     nslots;
    g.id           = iv.id;
    g.outcome      = lsia_pkg::OUT_PRECOLOR;
    g.reg_idx      = '0;
    g.victim_valid = 1'b0;
    g.victim_id    = '0;
    if (iv.run) begin
      for (cls = 0; cls < 2; cls++) begin
        for (k = 0; k < 8; k++) slot_busy[cls][k] = 1'b0;
      end
    end
    if (iv.pre) return g;
    // Free every slot of both classes whose owner died before this start.
    for (cls = 0; cls < 2; cls++) begin
      nslots = (cls == CLS_ADDR) ? ADDR_SLOTS : DATA_SLOTS;
      for (k = 0; k < nslots; k++) begin
        if (slot_busy[cls][k] && slot_end[cls][k] < iv.start_pos) slot_busy[cls][k] = 1'b0;
      end
    end
    cls    = iv.addr ? CLS_ADDR : CLS_DATA;
    nslots = iv.addr ? ADDR_SLOTS : DATA_SLOTS;
    cand   = -1;
    for (k = 0; k < nslots; k++) begin
      if (!slot_busy[cls][k] && cand < 0) cand = k;
    end
    if (cand >= 0) begin
      slot_busy[cls][cand]  = 1'b1;
      slot_end[cls][cand]   = iv.end_pos;
      slot_owner[cls][cand] = iv.id;
      g.outcome = iv.addr ? lsia_pkg::OUT_ADDR : lsia_pkg::OUT_DATA;
      g.reg_idx = cand[lsia_pkg::IDX_W-1:0];
      return g;
    end
    // Class is full: the latest end, lowest slot on ties, may be evicted.
    cand = 0;
    for (k = 1; k < nslots; k++) begin
      if (slot_end[cls][k] > slot_end[cls][cand]) cand = k;
    end
    if (slot_end[cls][cand] > iv.end_pos) begin
      g.victim_valid        = 1'b1;
      g.victim_id           = slot_owner[cls][cand];
      slot_end[cls][cand]   = iv.end_pos;
      slot_owner[cls][cand] = iv.id;
      g.outcome = iv.addr ? lsia_pkg::OUT_ADDR : lsia_pkg::OUT_DATA;
      g.reg_idx = cand[lsia_pkg::IDX_W-1:0];
    end else begin
      g.outcome = lsia_pkg::OUT_SPILL;
    end
    return g;
  endfunction

  // Input driver: predicts each accepted item and offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        grant_q.push_back(assign_register(cur_iv));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && (sent_cnt != recv_cnt || s_axis_tvalid))) begin
          cur_iv = pending_q.pop_front();
          s_axis_tdata  <= {7'd0, cur_iv.run, cur_iv.end_pos, cur_iv.start_pos, cur_iv.id};
          s_axis_tuser  <= {cur_iv.pre, cur_iv.addr};
          s_axis_tvalid <= 1'b1;
          gap_left      <= cur_iv.gap_after;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long output hold once the stream is well under way.
  always @(posedge clk) begin
    if (rst) begin
      long_hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && sent_cnt >= 400) begin
      long_hold_left <= 64;
      long_hold_done <= 1'b1;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  // Output monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      next_stall = (stall_left != 0) ? stall_left - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        recv_cnt <= recv_cnt + 1;
        if (grant_q.size() == 0) begin
          report_mismatch("result with no interval pending", 0, 32'(m_axis_tdata[15:0]));
        end else begin
          g = grant_q.pop_front();
          if (g.outcome == lsia_pkg::OUT_SPILL) n_spill++;
          if (g.outcome == lsia_pkg::OUT_PRECOLOR) n_precolor++;
          if (g.victim_valid) n_victim++;
          if (m_axis_tdata[15:0] !== g.id)
            report_mismatch("result_id", 32'(g.id), 32'(m_axis_tdata[15:0]));
          if (m_axis_tuser !== g.outcome)
            report_mismatch("outcome", 32'(g.outcome), 32'(m_axis_tuser));
          if (m_axis_tdata[18:16] !== g.reg_idx)
            report_mismatch("reg_index", 32'(g.reg_idx), 32'(m_axis_tdata[18:16]));
          if (m_axis_tdata[19] !== g.victim_valid)
            report_mismatch("victim_valid", 32'(g.victim_valid), 32'(m_axis_tdata[19]));
          if (m_axis_tdata[35:20] !== g.victim_id)
            report_mismatch("victim_id", 32'(g.victim_id), 32'(m_axis_tdata[35:20]));
        end
        next_stall = (((recv_cnt / 128) % 3) == 1) ? 0 : $urandom_range(0, 8);
      end
      stall_left    <= next_stall;
      m_axis_tready <= (next_stall == 0) && (long_hold_left == 0);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    interval_t iv;
    int        n;
    int        k;
    int        plen;
    int        pos;
    int        span;
    int        end_v;

    // Full data class: tie on the latest end, an equal end, a long newcomer.
    pending_q.push_back(interval_item(16'd1, 16'd10, 16'd200, 1'b0, 1'b0, 1'b1));
    pending_q.push_back(interval_item(16'd2, 16'd10, 16'd300, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd3, 16'd10, 16'd300, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd4, 16'd10, 16'd150, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd5, 16'd10, 16'd250, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd6, 16'd20, 16'd100, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd7, 16'd20, 16'd300, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd8, 16'd20, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    // Precolored intervals leave the slots alone.
    pending_q.push_back(interval_item(16'h00AA, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0));
    pending_q.push_back(interval_item(16'h5500, 16'd30, 16'd5, 1'b0, 1'b1, 1'b0));
    // Address class after expiry of all data slots, with an end below its start.
    iv = interval_item(16'd11, 16'd400, 16'd500, 1'b1, 1'b0, 1'b0);
    iv.drain = 1'b1;
    pending_q.push_back(iv);
    pending_q.push_back(interval_item(16'd12, 16'd400, 16'd450, 1'b1, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd13, 16'd401, 16'd420, 1'b1, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd14, 16'd410, 16'd300, 1'b1, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd15, 16'd460, 16'd470, 1'b1, 1'b0, 1'b0));
    // New procedure on a precolored interval, then the position extremes.
    pending_q.push_back(interval_item(16'd16, 16'd0, 16'hFFFF, 1'b0, 1'b1, 1'b1));
    pending_q.push_back(interval_item(16'd17, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd19, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1));
    pending_q.push_back(interval_item(16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0));
    pending_q.push_back(interval_item(16'd21, 16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0));

    // Mostly well-formed procedures with rising starts, some noise in between.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_q.push_back(interval_item(16'($urandom), 16'($urandom), 16'($urandom),
                                          1'($urandom),
                                          $urandom_range(0, 3) == 0,
                                          $urandom_range(0, 7) == 0));
        n++;
      end else begin
        plen = $urandom_range(4, 40);
        pos  = ($urandom_range(0, 4) == 0) ? $urandom_range(60000, 65535)
                                           : $urandom_range(0, 2000);
        span = ($urandom_range(0, 3) == 0) ? 400 : 40;
        for (k = 0; k < plen && n < RANDOM_ITEMS; k++) begin
          pos = pos + $urandom_range(0, 3);
          // A rare step backwards breaks the sorted order.
          if ($urandom_range(0, 29) == 0) pos = $urandom_range(0, pos);
          if (pos > 65535) pos = 65535;
          end_v = pos + $urandom_range(0, span);
          if (end_v > 65535) end_v = 65535;
          if ($urandom_range(0, 19) == 0) end_v = $urandom_range(0, pos);
          pending_q.push_back(interval_item(16'($urandom), pos[15:0], end_v[15:0],
                                            $urandom_range(0, 2) == 0,
                                            $urandom_range(0, 9) == 0, k == 0));
          n++;
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_q.size() == 0 && !s_axis_tvalid && sent_cnt == recv_cnt)) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (grant_q.size() != 0) report_mismatch("intervals left without a result", 0, grant_q.size());

    $display("Allocated %0d intervals in rising-start procedures plus noise,",
             sent_cnt);
    $display("with %0d spills, %0d evictions and %0d precolored pass-throughs.",
             n_spill, n_victim, n_precolor);
    if (err_cnt == 0) begin
      $display("** linear_scan_interval_allocator_core: PASSED **");
    end else begin
      $display("** linear_scan_interval_allocator_core: FAILED **");
    end
    $finish;
  end

  // Watchdog against a stuck handshake.
  initial begin
    #3000000;
    $display("** linear_scan_interval_allocator_core: FAILED **");
    $finish;
  end

endmodule
